@@ design/cbrf_pkg.sv @@
// ============================================================================
// cbrf_pkg
// Shared types and codes for the contiguous block ring FIFO address manager.
// ============================================================================
package cbrf_pkg;

    // operation codes
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_RESERVE = 2'd1;
    localparam logic [1:0] OP_COMMIT  = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_OVERSIZE   = 2'd1;
    localparam logic [1:0] ST_SHORT      = 2'd2;
    localparam logic [1:0] ST_COMMIT_ERR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_BUFFER_BYTES   = 2'd0;
    localparam logic [1:0] REG_RESERVE_OFFSET = 2'd1;
    localparam logic [1:0] REG_READ_GRAN_MAX  = 2'd2;
    localparam logic [1:0] REG_WRITE_GRAN_MAX = 2'd3;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 17;

    // configuration reset values
    localparam logic [16:0] BUFFER_BYTES_RST   = 17'd4096;
    localparam logic [15:0] RESERVE_OFFSET_RST = 16'd0;
    localparam logic [15:0] READ_GRAN_RST      = 16'd256;
    localparam logic [15:0] WRITE_GRAN_RST     = 16'd256;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] block_bytes;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] block_addr;
        logic [15:0] granted_bytes;
        logic        copy_needed;
        logic [15:0] copy_from;
    } out_item_t;

endpackage

@@ design/contiguous_block_ring_fifo.sv @@
// ============================================================================
// contiguous_block_ring_fifo
// Address manager for a byte ring buffer that only ever grants contiguous
// blocks. Each request is a read, a write reservation or a write commit and
// yields one result (opcode 3 is dropped with no result). A request is taken
// into an input register, evaluated against the pointer state in a single
// pass and the result lands in an output register: one request per clock is
// sustained while the result side does not stall. The rate is set by the
// pointer update loop.
// The output register decouples the sides, so a new request is still taken
// while a finished result waits unless that result is stalled and the input
// register already holds the next request. A wrapped read sets copy_needed:
// the caller must then have reserve_offset bytes copied from copy_from to
// address zero before using the block. Writing buffer_bytes or
// reserve_offset resets all pointers; write configuration only when idle.
// ============================================================================
module contiguous_block_ring_fifo
    import cbrf_pkg::*;
#(
    parameter int unsigned MAX_BUFFER_BYTES = 65536
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // buffer_bytes is 17 bits, so sizes never go above 131071
    localparam int unsigned BUF_CAP = (MAX_BUFFER_BYTES < 131071) ?
                                      MAX_BUFFER_BYTES : 131071;
    localparam int unsigned PTR_W   = $clog2(BUF_CAP + 1);

    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic             advance;    // output register can take a new value
    logic             fire;       // request in the input register is evaluated
    out_item_t        result;
    logic             has_result;

    logic [PTR_W-1:0] eff_buf, eff_off, init_buf, init_off;
    logic [15:0]      read_gran_max, write_gran_max;
    logic             reinit;

    cbrf_cfg #(
        .BUF_CAP (BUF_CAP),
        .PTR_W   (PTR_W)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .eff_buf        (eff_buf),
        .eff_off        (eff_off),
        .read_gran_max  (read_gran_max),
        .write_gran_max (write_gran_max),
        .reinit         (reinit),
        .init_buf       (init_buf),
        .init_off       (init_off)
    );

    cbrf_core #(
        .BUF_CAP (BUF_CAP),
        .PTR_W   (PTR_W)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .item           (in_item_reg),
        .eff_buf        (eff_buf),
        .eff_off        (eff_off),
        .read_gran_max  (read_gran_max),
        .write_gran_max (write_gran_max),
        .reinit         (reinit),
        .init_buf       (init_buf),
        .init_off       (init_off),
        .result         (result),
        .has_result     (has_result)
    );

    // output slot is free when empty or being drained this cycle
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    // input register holds when its request cannot move on
    assign in_stall = in_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_item_reg <= in_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && has_result)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // a stalled input only ever comes from a stalled, full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    // every evaluated request with a real opcode shows a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (in_item_reg.opcode != OP_NONE)) |=> out_valid)
        else $error("request evaluated but no result presented");

    // refused requests grant nothing
    a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status != ST_OK)) |->
        ((out_data.granted_bytes == 16'd0) && (out_data.block_addr == 16'd0) &&
         !out_data.copy_needed))
        else $error("refused request carries a grant");

    // copy_from stays zero whenever no tail copy is asked for
    a_copy_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.copy_needed) |-> (out_data.copy_from == 16'd0))
        else $error("copy source set without a copy");

endmodule

@@ design/cbrf_cfg.sv @@
// ============================================================================
// cbrf_cfg
// Configuration registers with clamped working values.
// ============================================================================
module cbrf_cfg
    import cbrf_pkg::*;
#(
    parameter int unsigned BUF_CAP = 65536,
    parameter int unsigned PTR_W   = 17
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [PTR_W-1:0]      eff_buf,
    output logic [PTR_W-1:0]      eff_off,
    output logic [15:0]           read_gran_max,
    output logic [15:0]           write_gran_max,
    output logic                  reinit,
    output logic [PTR_W-1:0]      init_buf,
    output logic [PTR_W-1:0]      init_off
);

    logic [16:0] buffer_bytes_reg, buffer_bytes_next;
    logic [15:0] reserve_offset_reg, reserve_offset_next;
    logic [15:0] read_gran_reg, read_gran_next;
    logic [15:0] write_gran_reg, write_gran_next;

    // buffer size held to 1..cap
    function automatic logic [PTR_W-1:0] clamp_buf(input logic [16:0] v);
        logic [16:0] c;
        if (v == 17'd0)
        begin
            c = 17'd1;
        end
        else if (32'(v) > BUF_CAP)
        begin
            c = 17'(BUF_CAP);
        end
        else
        begin
            c = v;
        end
        return PTR_W'(c);
    endfunction

    // offset held below the buffer size
    function automatic logic [PTR_W-1:0] clamp_off(input logic [15:0] v,
                                                   input logic [PTR_W-1:0] b);
        logic [16:0] bm1;
        logic [16:0] o;
        bm1 = 17'(b) - 17'd1;
        if ({1'b0, v} > bm1)
        begin
            o = bm1;
        end
        else
        begin
            o = {1'b0, v};
        end
        return PTR_W'(o);
    endfunction

    always_comb
    begin
        buffer_bytes_next   = buffer_bytes_reg;
        reserve_offset_next = reserve_offset_reg;
        read_gran_next      = read_gran_reg;
        write_gran_next     = write_gran_reg;
        reinit              = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BUFFER_BYTES:
                begin
                    buffer_bytes_next = cfg_data;
                    reinit            = 1'b1;
                end
                REG_RESERVE_OFFSET:
                begin
                    reserve_offset_next = cfg_data[15:0];
                    reinit              = 1'b1;
                end
                REG_READ_GRAN_MAX:  read_gran_next  = cfg_data[15:0];
                REG_WRITE_GRAN_MAX: write_gran_next = cfg_data[15:0];
                default:            reinit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_bytes_reg   <= BUFFER_BYTES_RST;
            reserve_offset_reg <= RESERVE_OFFSET_RST;
            read_gran_reg      <= READ_GRAN_RST;
            write_gran_reg     <= WRITE_GRAN_RST;
        end
        else
        begin
            buffer_bytes_reg   <= buffer_bytes_next;
            reserve_offset_reg <= reserve_offset_next;
            read_gran_reg      <= read_gran_next;
            write_gran_reg     <= write_gran_next;
        end
    end

    assign eff_buf        = clamp_buf(buffer_bytes_reg);
    assign eff_off        = clamp_off(reserve_offset_reg, eff_buf);
    assign init_buf       = clamp_buf(buffer_bytes_next);
    assign init_off       = clamp_off(reserve_offset_next, init_buf);
    assign read_gran_max  = read_gran_reg;
    assign write_gran_max = write_gran_reg;

endmodule

@@ design/cbrf_core.sv @@
// ============================================================================
// cbrf_core
// Pointer state and single-pass grant logic for read, reserve and commit.
// ============================================================================
module cbrf_core
    import cbrf_pkg::*;
#(
    parameter int unsigned BUF_CAP = 65536,
    parameter int unsigned PTR_W   = 17
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  in_item_t         item,
    input  logic [PTR_W-1:0] eff_buf,
    input  logic [PTR_W-1:0] eff_off,
    input  logic [15:0]      read_gran_max,
    input  logic [15:0]      write_gran_max,
    input  logic             reinit,
    input  logic [PTR_W-1:0] init_buf,
    input  logic [PTR_W-1:0] init_off,
    output out_item_t        result,
    output logic             has_result
);

    // arithmetic width: room for a pointer or a size plus one carry bit
    localparam int unsigned AW = ((PTR_W > 16) ? PTR_W : 16) + 1;
    // reset buffer size after clamping to the cap (offset resets to zero)
    localparam int unsigned RST_BUF = (32'(BUFFER_BYTES_RST) > BUF_CAP) ?
                                      BUF_CAP : 32'(BUFFER_BYTES_RST);

    logic [PTR_W-1:0] rd_pos_reg,   rd_pos_next;
    logic [PTR_W-1:0] wr_pos_reg,   wr_pos_next;
    logic [PTR_W-1:0] last_res_reg, last_res_next;
    logic [PTR_W-1:0] rd_limit_reg, rd_limit_next;
    logic [PTR_W-1:0] readable_reg, readable_next;
    logic [PTR_W-1:0] writable_reg, writable_next;

    logic [AW-1:0] n_w, rp_w, wp_w, lr_w, rl_w, rd_w, wr_w, b_w, o_w, size_w;
    logic [AW-1:0] rp_sum, wp_sum, o_sum, lr_sum;
    logic [AW-1:0] unread, wrap_addr, copy_src, wrap_end;
    logic [AW-1:0] reserved, unwritten, rd_left, rd_commit;

    assign n_w    = AW'(item.block_bytes);
    assign rp_w   = AW'(rd_pos_reg);
    assign wp_w   = AW'(wr_pos_reg);
    assign lr_w   = AW'(last_res_reg);
    assign rl_w   = AW'(rd_limit_reg);
    assign rd_w   = AW'(readable_reg);
    assign wr_w   = AW'(writable_reg);
    assign b_w    = AW'(eff_buf);
    assign o_w    = AW'(eff_off);
    assign size_w = b_w - o_w;

    assign rp_sum = rp_w + n_w;
    assign wp_sum = wp_w + n_w;
    assign o_sum  = o_w + n_w;
    assign lr_sum = lr_w + n_w;

    // wrapped read: unread tail sits in the mirrored prefix
    assign unread    = (rl_w >= rp_w) ? (rl_w - rp_w) : '0;
    assign wrap_addr = (o_w >= unread) ? (o_w - unread) : '0;
    assign copy_src  = (rl_w >= o_w) ? (rl_w - o_w) : '0;
    assign wrap_end  = wrap_addr + n_w;

    // commit: give back what was reserved but not written
    assign reserved  = wp_w - lr_w;
    assign unwritten = reserved - n_w;
    assign rd_left   = (rd_w > unwritten) ? (rd_w - unwritten) : '0;
    assign rd_commit = (rd_left > size_w) ? size_w : rd_left;

    always_comb
    begin
        rd_pos_next   = rd_pos_reg;
        wr_pos_next   = wr_pos_reg;
        last_res_next = last_res_reg;
        rd_limit_next = rd_limit_reg;
        readable_next = readable_reg;
        writable_next = writable_reg;
        result        = '0;
        has_result    = 1'b1;
        case (item.opcode)
            OP_READ:
            begin
                if (n_w > AW'(read_gran_max))
                begin
                    result.status = ST_OVERSIZE;
                end
                else if (n_w > rd_w)
                begin
                    result.status = ST_SHORT;
                end
                else
                begin
                    result.status        = ST_OK;
                    result.granted_bytes = item.block_bytes;
                    if (rp_sum <= rl_w)
                    begin
                        result.block_addr = rp_w[15:0];
                        rd_pos_next       = PTR_W'(rp_sum);
                    end
                    else
                    begin
                        result.block_addr  = wrap_addr[15:0];
                        result.copy_needed = 1'b1;
                        result.copy_from   = copy_src[15:0];
                        rd_pos_next        = PTR_W'(wrap_end);
                        rd_limit_next      = eff_buf;
                    end
                    writable_next = PTR_W'(wr_w + n_w);
                    readable_next = PTR_W'(rd_w - n_w);
                end
            end
            OP_RESERVE:
            begin
                if (n_w > AW'(write_gran_max))
                begin
                    result.status = ST_OVERSIZE;
                end
                else if (n_w > wr_w)
                begin
                    result.status = ST_SHORT;
                end
                else
                begin
                    result.status        = ST_OK;
                    result.granted_bytes = item.block_bytes;
                    if (wp_sum <= b_w)
                    begin
                        result.block_addr = wp_w[15:0];
                        last_res_next     = wr_pos_reg;
                        wr_pos_next       = PTR_W'(wp_sum);
                    end
                    else
                    begin
                        result.block_addr = o_w[15:0];
                        last_res_next     = eff_off;
                        rd_limit_next     = wr_pos_reg;
                        wr_pos_next       = PTR_W'(o_sum);
                    end
                    readable_next = PTR_W'(rd_w + n_w);
                    writable_next = PTR_W'(wr_w - n_w);
                end
            end
            OP_COMMIT:
            begin
                if ((wp_w < lr_w) || (n_w > reserved))
                begin
                    result.status = ST_COMMIT_ERR;
                end
                else
                begin
                    result.status        = ST_OK;
                    result.block_addr    = lr_w[15:0];
                    result.granted_bytes = item.block_bytes;
                    readable_next        = PTR_W'(rd_commit);
                    writable_next        = PTR_W'(size_w - rd_commit);
                    wr_pos_next          = PTR_W'(lr_sum);
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pos_reg   <= '0;
            wr_pos_reg   <= '0;
            last_res_reg <= '0;
            rd_limit_reg <= PTR_W'(RST_BUF);
            readable_reg <= '0;
            writable_reg <= PTR_W'(RST_BUF);
        end
        else if (reinit)
        begin
            rd_pos_reg   <= init_off;
            wr_pos_reg   <= init_off;
            last_res_reg <= init_off;
            rd_limit_reg <= init_buf;
            readable_reg <= '0;
            writable_reg <= init_buf - init_off;
        end
        else if (fire)
        begin
            rd_pos_reg   <= rd_pos_next;
            wr_pos_reg   <= wr_pos_next;
            last_res_reg <= last_res_next;
            rd_limit_reg <= rd_limit_next;
            readable_reg <= readable_next;
            writable_reg <= writable_next;
        end
    end

endmodule

@@ dv/tb_top.sv @@
// ============================================================================
// tb_top
// Self-checking bench for the contiguous block ring FIFO address manager.
// A directed table runs first, covering size extremes, every operation,
// error codes, wrapped reservations, wrapped reads with a tail copy,
// saturating counts and the address wrap at the buffer end. Random phases
// with fresh register settings follow. Most random requests are reserve,
// commit and read sequences sized from the predicted pointer state; the rest
// are noise. Each accepted request is run through a bench-side model of the
// pointer logic, and every result is compared field by field, in order.
// ============================================================================
module tb_top
    import cbrf_pkg::*;
();

    localparam int unsigned MAX_BYTES       = 65536;
    localparam int          PHASES          = 10;
    localparam int          ITEMS_PER_PHASE = 70;
    localparam int          LONG_HOLD_AT    = 150;   // result count that triggers the long stall
    localparam int          LONG_HOLD_CYC   = 80;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports (all inputs known from time zero)
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    contiguous_block_ring_fifo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench-side copy of the registers and the pointer state
    // ------------------------------------------------------------------------
    logic [16:0] conf_buf   = BUFFER_BYTES_RST;
    logic [15:0] conf_off   = RESERVE_OFFSET_RST;
    logic [15:0] conf_rgran = READ_GRAN_RST;
    logic [15:0] conf_wgran = WRITE_GRAN_RST;

    logic [16:0] rd_ptr;      // next byte to read
    logic [16:0] wr_ptr;      // next byte to reserve
    logic [16:0] resv_start;  // start of the last reservation
    logic [16:0] rd_end;      // where reading stops before it wraps
    logic [16:0] fill_cnt;    // readable bytes (reserved ones included)
    logic [16:0] free_cnt;    // writable bytes

    out_item_t   pending_grants[$];   // results still owed by the block, oldest first
    int          mismatches = 0;
    bit          calm_tx    = 1'b0;   // sender offers back to back
    bit          calm_rx    = 1'b0;   // receiver never stalls (except the long hold)

    // buffer_bytes as the block uses it: clamped to 1..MAX_BYTES
    function automatic int unsigned region_end();
        if (conf_buf == 0)
            return 1;
        if (32'(conf_buf) > MAX_BYTES)
            return MAX_BYTES;
        return 32'(conf_buf);
    endfunction

    // reserve_offset clamped below the region end
    function automatic int unsigned region_start();
        int unsigned b;
        b = region_end();
        return (32'(conf_off) > b - 1) ? b - 1 : 32'(conf_off);
    endfunction

    function automatic void restart_pointers();
        int unsigned b, o;
        b          = region_end();
        o          = region_start();
        rd_ptr     = 17'(o);
        wr_ptr     = 17'(o);
        resv_start = 17'(o);
        rd_end     = 17'(b);
        fill_cnt   = '0;
        free_cnt   = 17'(b - o);
    endfunction

    // writing the buffer size or the offset throws away all pointer state
    function automatic void apply_reg(input logic [1:0] idx, input logic [16:0] value);
        case (idx)
            REG_BUFFER_BYTES:
            begin
                conf_buf = value;
                restart_pointers();
            end
            REG_RESERVE_OFFSET:
            begin
                conf_off = value[15:0];
                restart_pointers();
            end
            REG_READ_GRAN_MAX:  conf_rgran = value[15:0];
            default:            conf_wgran = value[15:0];
        endcase
    endfunction

    // Works out the block's answer to one request and advances the pointer
    // state. Returns 0 for a request that yields no result.
    function automatic bit predict_block(input in_item_t req, output out_item_t grant);
        int unsigned b, o, span, n, unread, at, reserved, unwritten;
        b     = region_end();
        o     = region_start();
        span  = b - o;
        n     = 32'(req.block_bytes);
        grant = '0;
        at    = 0;
        case (req.opcode)
            OP_READ:
            begin
                if (n > 32'(conf_rgran))
                    grant.status = ST_OVERSIZE;
                else if (n > 32'(fill_cnt))
                    grant.status = ST_SHORT;
                else
                begin
                    if (32'(rd_ptr) + n <= 32'(rd_end))
                    begin
                        at     = 32'(rd_ptr);
                        rd_ptr = 17'(at + n);
                    end
                    else
                    begin
                        // block is placed so it starts where the unread tail lands
                        // after the region's tail copy; start saturates at zero
                        unread = (rd_end >= rd_ptr) ? 32'(rd_end - rd_ptr) : 0;
                        at     = (o >= unread) ? o - unread : 0;
                        grant.copy_needed = 1'b1;
                        grant.copy_from   = 16'((32'(rd_end) >= o) ? 32'(rd_end) - o : 0);
                        rd_ptr = 17'(at + n);
                        rd_end = 17'(b);
                    end
                    free_cnt            = 17'(32'(free_cnt) + n);
                    fill_cnt            = 17'(32'(fill_cnt) - n);
                    grant.status        = ST_OK;
                    grant.block_addr    = 16'(at);
                    grant.granted_bytes = 16'(n);
                end
                return 1'b1;
            end
            OP_RESERVE:
            begin
                if (n > 32'(conf_wgran))
                    grant.status = ST_OVERSIZE;
                else if (n > 32'(free_cnt))
                    grant.status = ST_SHORT;
                else
                begin
                    if (32'(wr_ptr) + n <= b)
                    begin
                        at     = 32'(wr_ptr);
                        wr_ptr = 17'(at + n);
                    end
                    else
                    begin
                        // restart at region start; reads now stop at old write pointer
                        at     = o;
                        rd_end = wr_ptr;
                        wr_ptr = 17'(o + n);
                    end
                    resv_start          = 17'(at);
                    fill_cnt            = 17'(32'(fill_cnt) + n);
                    free_cnt            = 17'(32'(free_cnt) - n);
                    grant.status        = ST_OK;
                    grant.block_addr    = 16'(at);   // an offset of 65536 wraps to 0
                    grant.granted_bytes = 16'(n);
                end
                return 1'b1;
            end
            OP_COMMIT:
            begin
                if (wr_ptr < resv_start)
                begin
                    grant.status = ST_COMMIT_ERR;
                    return 1'b1;
                end
                reserved = 32'(wr_ptr - resv_start);
                if (n > reserved)
                begin
                    grant.status = ST_COMMIT_ERR;
                    return 1'b1;
                end
                // hand back the unwritten part; readable may already have been consumed
                unwritten = reserved - n;
                if (32'(fill_cnt) > unwritten)
                    fill_cnt = 17'(32'(fill_cnt) - unwritten);
                else
                    fill_cnt = '0;
                if (32'(fill_cnt) > span)
                    fill_cnt = 17'(span);
                free_cnt            = 17'(span - 32'(fill_cnt));
                wr_ptr              = 17'(32'(resv_start) + n);
                grant.status        = ST_OK;
                grant.block_addr    = resv_start[15:0];
                grant.granted_bytes = 16'(n);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Random request: mostly well-formed, sized from the predicted state
    // ------------------------------------------------------------------------
    function automatic in_item_t draw_request();
        in_item_t    r;
        int unsigned roll, cap;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            // noise: any opcode, any size (mostly oversize, short or commit errors)
            r.opcode      = 2'($urandom_range(0, 3));
            r.block_bytes = 16'($urandom_range(0, 65535));
        end
        else if (roll < 45)
        begin
            cap           = (32'(free_cnt) < 32'(conf_wgran)) ? 32'(free_cnt)
                                                              : 32'(conf_wgran);
            r.opcode      = OP_RESERVE;
            r.block_bytes = 16'($urandom_range(0, cap));
        end
        else if (roll < 70)
        begin
            cap           = (wr_ptr >= resv_start) ? 32'(wr_ptr - resv_start) : 0;
            cap           = (cap > 65535) ? 65535 : cap;
            r.opcode      = OP_COMMIT;
            r.block_bytes = 16'($urandom_range(0, cap));
        end
        else
        begin
            cap           = (32'(fill_cnt) < 32'(conf_rgran)) ? 32'(fill_cnt)
                                                              : 32'(conf_rgran);
            r.opcode      = OP_READ;
            r.block_bytes = 16'($urandom_range(0, cap));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Offers one request after a random gap and waits until it is taken.
    // Valid stays high afterwards so back-to-back requests need no toggle.
    task automatic push_request(input in_item_t req, input bit typed, input out_item_t want);
        int        gap;
        out_item_t grant;
        gap = calm_tx ? 0 : $urandom_range(0, 11);
        cfg_we <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_block(req, grant))
            pending_grants.push_back(typed ? want : grant);
    endtask

    // stop offering until every owed result is back; then let an
    // opcode 3 request still in the pipe fall through
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // only called while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        apply_reg(idx, value);
    endtask

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    typedef enum bit {ROW_REQ, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  code;    // opcode, or register index for ROW_REG
        logic [16:0] value;   // block_bytes, or register data
        bit          typed;   // 1: use want below instead of the model
        out_item_t   want;
    } plan_row_t;

    localparam out_item_t NO_WANT = '0;

    plan_row_t plan [34] = '{
        // reset settings: 4096 byte buffer, no offset, granules of 256
        '{ROW_REQ, OP_READ,    17'd0,     1'b1, {ST_OK, 49'd0}},
        '{ROW_REQ, OP_READ,    17'd1,     1'b1, {ST_SHORT, 49'd0}},
        '{ROW_REQ, OP_READ,    17'd257,   1'b1, {ST_OVERSIZE, 49'd0}},
        '{ROW_REQ, OP_RESERVE, 17'd65535, 1'b1, {ST_OVERSIZE, 49'd0}},
        '{ROW_REQ, OP_COMMIT,  17'd1,     1'b1, {ST_COMMIT_ERR, 49'd0}},
        '{ROW_REQ, OP_NONE,    17'd65535, 1'b0, NO_WANT},   // dropped, no result
        '{ROW_REQ, OP_RESERVE, 17'd256,   1'b1, {ST_OK, 16'd0, 16'd256, 1'b0, 16'd0}},
        '{ROW_REQ, OP_COMMIT,  17'd100,   1'b1, {ST_OK, 16'd0, 16'd100, 1'b0, 16'd0}},
        '{ROW_REQ, OP_READ,    17'd100,   1'b1, {ST_OK, 16'd0, 16'd100, 1'b0, 16'd0}},
        // 16 byte buffer, 4 byte prefix, widest granules
        '{ROW_REG, REG_BUFFER_BYTES,   17'd16,    1'b0, NO_WANT},
        '{ROW_REG, REG_RESERVE_OFFSET, 17'd4,     1'b0, NO_WANT},
        '{ROW_REG, REG_READ_GRAN_MAX,  17'd65535, 1'b0, NO_WANT},
        '{ROW_REG, REG_WRITE_GRAN_MAX, 17'd65535, 1'b0, NO_WANT},
        '{ROW_REQ, OP_RESERVE, 17'd8,  1'b0, NO_WANT},
        '{ROW_REQ, OP_COMMIT,  17'd8,  1'b0, NO_WANT},
        '{ROW_REQ, OP_READ,    17'd6,  1'b0, NO_WANT},
        '{ROW_REQ, OP_RESERVE, 17'd6,  1'b0, NO_WANT},   // passes the end, restarts
        '{ROW_REQ, OP_COMMIT,  17'd6,  1'b0, NO_WANT},
        '{ROW_REQ, OP_READ,    17'd4,  1'b0, NO_WANT},   // wrapped read, tail copy
        '{ROW_REQ, OP_RESERVE, 17'd4,  1'b0, NO_WANT},
        '{ROW_REQ, OP_READ,    17'd8,  1'b0, NO_WANT},   // reads reserved bytes
        '{ROW_REQ, OP_COMMIT,  17'd0,  1'b0, NO_WANT},   // readable saturates at zero
        // 1 byte prefix: a wrapped read whose start saturates at zero
        '{ROW_REG, REG_RESERVE_OFFSET, 17'd1, 1'b0, NO_WANT},
        '{ROW_REQ, OP_RESERVE, 17'd12, 1'b0, NO_WANT},
        '{ROW_REQ, OP_COMMIT,  17'd12, 1'b0, NO_WANT},
        '{ROW_REQ, OP_READ,    17'd2,  1'b0, NO_WANT},
        '{ROW_REQ, OP_RESERVE, 17'd5,  1'b0, NO_WANT},
        '{ROW_REQ, OP_READ,    17'd12, 1'b0, NO_WANT},
        // oversized buffer clamps to the maximum; zero grant at the end wraps
        '{ROW_REG, REG_BUFFER_BYTES,   17'd131071, 1'b0, NO_WANT},
        '{ROW_REG, REG_RESERVE_OFFSET, 17'd0,      1'b0, NO_WANT},
        '{ROW_REQ, OP_RESERVE, 17'd65535, 1'b0, NO_WANT},
        '{ROW_REQ, OP_RESERVE, 17'd1,     1'b0, NO_WANT},
        '{ROW_REQ, OP_RESERVE, 17'd0,     1'b0, NO_WANT},
        '{ROW_REQ, OP_READ,    17'd65535, 1'b0, NO_WANT}
    };

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, then random phases
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        in_item_t    req;
        int unsigned bb, ro, rg, wg;
        int          counted;
        restart_pointers();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                if (i > 0 && plan[i-1].kind != ROW_REG)
                    wait_drained();
                write_reg(plan[i].code, plan[i].value);
            end
            else
            begin
                req.opcode      = plan[i].code;
                req.block_bytes = plan[i].value[15:0];
                push_request(req, plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            calm_tx = (p % 3 == 0);
            calm_rx = (p % 3 == 1);
            case (p)
                0:
                begin
                    bb = 16;     ro = 0;     rg = 65535; wg = 65535;
                end
                1:
                begin
                    bb = 1;      ro = 0;     rg = 1;     wg = 65535;
                end
                2:
                begin
                    bb = 0;      ro = 65535; rg = 65535; wg = 1;      // both clamp
                end
                3:
                begin
                    bb = 131071; ro = 65535; rg = 1;     wg = 1;
                end
                4:
                begin
                    bb = 65536;  ro = 0;     rg = 65535; wg = 65535;
                end
                default:
                begin
                    bb = $urandom_range(2, 300);
                    ro = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, bb - 1);
                    rg = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1, 64);
                    wg = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 64);
                end
            endcase
            write_reg(REG_BUFFER_BYTES, 17'(bb));
            write_reg(REG_RESERVE_OFFSET, 17'(ro));
            write_reg(REG_READ_GRAN_MAX, 17'(rg));
            write_reg(REG_WRITE_GRAN_MAX, 17'(wg));

            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                // sender pauses mid-phase until everything has come back
                if (p == 4 && counted == ITEMS_PER_PHASE / 2)
                    wait_drained();
                req = draw_request();
                push_request(req, 1'b0, NO_WANT);
                if (req.opcode != OP_NONE)
                    counted++;
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, one long hold, in-order checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    initial
    begin : result_sink
        int        hold;
        int        taken;
        out_item_t want;
        hold  = 0;
        taken = 0;
        forever
        begin
            @(posedge clk);
            // values seen here are the ones from before the edge
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_grants.size() == 0)
                begin
                    $error("unexpected result: status %0d addr %0d bytes %0d",
                           out_data.status, out_data.block_addr, out_data.granted_bytes);
                    mismatches++;
                end
                else
                begin
                    want = pending_grants.pop_front();
                    check_field("status", want.status, out_data.status);
                    check_field("block_addr", want.block_addr, out_data.block_addr);
                    check_field("granted_bytes", want.granted_bytes, out_data.granted_bytes);
                    check_field("copy_needed", want.copy_needed, out_data.copy_needed);
                    check_field("copy_from", want.copy_from, out_data.copy_from);
                end
                taken++;
                // once, hold off long enough for the block to back up into its input
                if (taken == LONG_HOLD_AT)
                    hold = LONG_HOLD_CYC;
                else
                    hold = calm_rx ? 0 : $urandom_range(0, 11);
            end
            out_stall <= (hold > 0);
            if (hold > 0)
                hold--;
        end
    end

    // run limit, far beyond the slowest correct run
    initial
    begin : watchdog
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
design/cbrf_pkg.sv
design/cbrf_cfg.sv
design/cbrf_core.sv
design/contiguous_block_ring_fifo.sv
dv/tb_top.sv
